[hdl/lslt_pkg.sv]
// ----------------------------------------------------------------------------
// lslt_pkg
// Shared constants, types and configuration codes of the light and sound
// level trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package lslt_pkg;

    localparam int TICKS_PER_WINDOW   = 5;
    localparam int WINDOWS_PER_REPORT = 14;

    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 17;
    localparam int AMP_W      = 12;
    localparam int DUTY_W     = 7;
    localparam int STHR_W     = 12;
    localparam int LTHR_W     = 16;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int LACC_W = 23;
    localparam int AACC_W = 16;
    localparam int TICK_W = $clog2(TICKS_PER_WINDOW + 1);
    localparam int WIN_W  = $clog2(WINDOWS_PER_REPORT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Light scaling x*65536/4095 = 16x + floor(16x/4095)
    localparam int                  SCALED_W   = 16;
    localparam logic [SAMPLE_W:0]   FULL_SCALE = 13'd4095;

    // Reciprocal division of the sums: exact for every sum of the accumulator width
    localparam int LIGHT_DIV     = TICKS_PER_WINDOW * WINDOWS_PER_REPORT;
    localparam int LIGHT_SHIFT   = LACC_W + $clog2(LIGHT_DIV);
    localparam int LIGHT_RECIP_W = LACC_W + 1;
    localparam int LPROD_W       = LACC_W + LIGHT_RECIP_W;
    localparam logic [LIGHT_RECIP_W-1:0] LIGHT_RECIP =
        LIGHT_RECIP_W'(((64'd1 << LIGHT_SHIFT) + 64'(LIGHT_DIV) - 64'd1) / 64'(LIGHT_DIV));

    localparam int AMP_DIV     = WINDOWS_PER_REPORT;
    localparam int AMP_SHIFT   = AACC_W + $clog2(AMP_DIV);
    localparam int AMP_RECIP_W = AACC_W + 1;
    localparam int APROD_W     = AACC_W + AMP_RECIP_W;
    localparam logic [AMP_RECIP_W-1:0] AMP_RECIP =
        AMP_RECIP_W'(((64'd1 << AMP_SHIFT) + 64'(AMP_DIV) - 64'd1) / 64'(AMP_DIV));

    // Duty: 100 - ceil(min(amp,1000)/10), the tenth taken as (t*205)>>11
    localparam int                  CAP_W        = 10;
    localparam logic [CAP_W-1:0]    AMP_CAP      = 10'd1000;
    localparam logic [CAP_W-1:0]    DUTY_ROUND   = 10'd9;
    localparam int                  DIV10_W      = 18;
    localparam logic [DIV10_W-1:0]  DIV10_RECIP  = 18'd205;
    localparam int                  DIV10_SHIFT  = 11;
    localparam logic [DUTY_W-1:0]   DUTY_OFF     = 7'd100;

    localparam logic [SAMPLE_W-1:0] PEAK_LOW_RST = 12'hFFF;

    localparam logic [STHR_W-1:0] SOUND_THR_RST = 12'd620;
    localparam logic [LTHR_W-1:0] LIGHT_THR_RST = 16'd500;
    localparam logic [HOLD_W-1:0] HOLD_RST      = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOUND_THR = 2'd0,
        CFG_LIGHT_THR = 2'd1,
        CFG_HOLD      = 2'd2,
        CFG_MODE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [STHR_W-1:0] sound_limit;
        logic [LTHR_W-1:0] light_limit;
        logic [HOLD_W-1:0] hold_ticks;
        logic              sound_lamp_mode;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0]  scaled_light;
        logic [SAMPLE_W-1:0] sound_sample;
    } t_front_item;

    typedef struct packed {
        logic              report;
        logic [LACC_W-1:0] light_total;
        logic [AACC_W-1:0] amp_sum;
    } t_acc_item;

    typedef struct packed {
        logic              active;
        logic [HOLD_W-1:0] elapsed;
    } t_lamp;

endpackage

`default_nettype wire

[hdl/lslt_sample_if.sv]
// ----------------------------------------------------------------------------
// lslt_sample_if
// Sample channel: one light and one sound sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lslt_sample_if;
    logic                          valid;
    logic                          ready;
    logic [lslt_pkg::SAMPLE_W-1:0] light_sample;
    logic [lslt_pkg::SAMPLE_W-1:0] sound_sample;

    modport source (output valid, light_sample, sound_sample, input ready);
    modport sink   (input valid, light_sample, sound_sample, output ready);
endinterface

`default_nettype wire

[hdl/lslt_result_if.sv]
// ----------------------------------------------------------------------------
// lslt_result_if
// Result channel: averages, lamp states and duty per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lslt_result_if;
    logic                         valid;
    logic                         ready;
    logic [lslt_pkg::LEVEL_W-1:0] light_level;
    logic [lslt_pkg::AMP_W-1:0]   sound_amplitude;
    logic                         report_done;
    logic                         sound_lamp_on;
    logic                         light_lamp_on;
    logic [lslt_pkg::DUTY_W-1:0]  proportional_duty;

    modport source (output valid, light_level, sound_amplitude, report_done,
                    sound_lamp_on, light_lamp_on, proportional_duty, input ready);
    modport sink   (input valid, light_level, sound_amplitude, report_done,
                    sound_lamp_on, light_lamp_on, proportional_duty, output ready);
endinterface

`default_nettype wire

[hdl/lslt_front.sv]
// ----------------------------------------------------------------------------
// lslt_front
// Input register: take a sample pair and scale the light sample to 0..65536.
// ----------------------------------------------------------------------------
`default_nettype none

module lslt_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lslt_sample_if.sink                i_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output lslt_pkg::t_front_item      o_item
);

    logic                             r_valid;
    lslt_pkg::t_front_item            r_item;
    lslt_pkg::t_front_item            n_item;
    logic                             take;
    logic [lslt_pkg::SCALED_W-1:0]    times16;
    logic [3:0]                       q0;
    logic [lslt_pkg::SAMPLE_W:0]      rem;
    logic                             carry;

    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        times16 = {i_in.light_sample, 4'b0000};
        q0      = times16[lslt_pkg::SCALED_W-1 -: 4];
        rem     = {1'b0, times16[lslt_pkg::SAMPLE_W-1:0]} + (lslt_pkg::SAMPLE_W + 1)'(q0);
        carry   = rem >= lslt_pkg::FULL_SCALE;
        n_item.scaled_light = {1'b0, times16} + lslt_pkg::LEVEL_W'(q0)
                              + lslt_pkg::LEVEL_W'(carry);
        n_item.sound_sample = i_in.sound_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/lslt_queue.sv]
// ----------------------------------------------------------------------------
// lslt_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lslt_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire lslt_pkg::t_front_item i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output lslt_pkg::t_front_item      o_item
);

    lslt_pkg::t_front_item         r_mem [lslt_pkg::QUEUE_DEPTH];
    logic [lslt_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [lslt_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [lslt_pkg::QCNT_W-1:0]   r_count;
    logic                          push;
    logic                          pop;

    assign o_ready = r_count != lslt_pkg::QCNT_W'(lslt_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    function automatic logic [lslt_pkg::QPTR_W-1:0] advance(
        input logic [lslt_pkg::QPTR_W-1:0] ptr
    );
        return (ptr == lslt_pkg::QPTR_W'(lslt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= advance(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= advance(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[hdl/lslt_back.sv]
// ----------------------------------------------------------------------------
// lslt_back
// Accumulate and window, divide the sums at report time, run the lamp hold
// and the duty, and hold the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lslt_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lslt_pkg::t_cfg        i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire lslt_pkg::t_front_item i_item,
    lslt_result_if.source              o_out
);

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;
    logic accept;

    // accumulate stage
    logic [lslt_pkg::LACC_W-1:0]   r_lacc;
    logic [lslt_pkg::AACC_W-1:0]   r_aacc;
    logic [lslt_pkg::SAMPLE_W-1:0] r_peak_hi;
    logic [lslt_pkg::SAMPLE_W-1:0] r_peak_lo;
    logic [lslt_pkg::TICK_W-1:0]   r_tick;
    logic [lslt_pkg::WIN_W-1:0]    r_win;
    lslt_pkg::t_acc_item           r_acc;

    logic [lslt_pkg::SAMPLE_W-1:0] peak_hi;
    logic [lslt_pkg::SAMPLE_W-1:0] peak_lo;
    logic [lslt_pkg::SAMPLE_W-1:0] window_amp;
    logic [lslt_pkg::TICK_W-1:0]   tick_inc;
    logic [lslt_pkg::WIN_W-1:0]    win_inc;
    logic                          win_end;
    lslt_pkg::t_acc_item           n_acc;

    // multiply stage
    logic [lslt_pkg::LPROD_W-1:0]  r_lprod;
    logic [lslt_pkg::APROD_W-1:0]  r_aprod;
    logic                          r_rep2;

    // lamp and duty stage
    logic [lslt_pkg::LEVEL_W-1:0]  r_avg_l;
    logic [lslt_pkg::AMP_W-1:0]    r_avg_a;
    lslt_pkg::t_lamp               r_slamp;
    lslt_pkg::t_lamp               r_llamp;
    logic                          r_rep3;
    logic                          r_sound_on;
    logic [lslt_pkg::DUTY_W-1:0]   r_duty;

    logic [lslt_pkg::LEVEL_W-1:0]  n_avg_l;
    logic [lslt_pkg::AMP_W-1:0]    n_avg_a;
    lslt_pkg::t_lamp               n_slamp;
    lslt_pkg::t_lamp               n_llamp;
    logic [lslt_pkg::DUTY_W-1:0]   n_duty;
    logic [lslt_pkg::CAP_W-1:0]    amp_cap;
    logic [lslt_pkg::CAP_W-1:0]    round_up;
    logic [lslt_pkg::DIV10_W-1:0]  tenth_prod;
    logic [lslt_pkg::DUTY_W-1:0]   tenth;

    assign en3     = !r_v3 || o_out.ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign accept  = i_valid && en1;

    function automatic lslt_pkg::t_lamp lamp_step(
        input logic                            trig,
        input lslt_pkg::t_lamp                 cur,
        input logic [lslt_pkg::HOLD_W-1:0]     hold
    );
        lslt_pkg::t_lamp nxt;
        nxt = cur;
        if (trig) begin
            nxt.active  = 1'b1;
            nxt.elapsed = '0;
        end else if (cur.active) begin
            if (cur.elapsed != '1) begin
                nxt.elapsed = cur.elapsed + 1'b1;
            end
            if (nxt.elapsed >= hold) begin
                nxt.active = 1'b0;
            end
        end
        return nxt;
    endfunction

    always_comb begin
        peak_hi    = (i_item.sound_sample > r_peak_hi) ? i_item.sound_sample : r_peak_hi;
        peak_lo    = (i_item.sound_sample < r_peak_lo) ? i_item.sound_sample : r_peak_lo;
        window_amp = peak_hi - peak_lo;
        tick_inc   = lslt_pkg::TICK_W'(r_tick + 1'b1);
        win_end    = tick_inc == lslt_pkg::TICK_W'(lslt_pkg::TICKS_PER_WINDOW);
        win_inc    = r_win + lslt_pkg::WIN_W'(win_end);
        n_acc.light_total = r_lacc + lslt_pkg::LACC_W'(i_item.scaled_light);
        n_acc.amp_sum     = r_aacc + (win_end ? lslt_pkg::AACC_W'(window_amp)
                                              : lslt_pkg::AACC_W'(0));
        n_acc.report      = win_inc == lslt_pkg::WIN_W'(lslt_pkg::WINDOWS_PER_REPORT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_lacc    <= '0;
            r_aacc    <= '0;
            r_peak_hi <= '0;
            r_peak_lo <= lslt_pkg::PEAK_LOW_RST;
            r_tick    <= '0;
            r_win     <= '0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (accept) begin
                r_lacc    <= n_acc.report ? '0 : n_acc.light_total;
                r_aacc    <= n_acc.report ? '0 : n_acc.amp_sum;
                r_win     <= n_acc.report ? '0 : win_inc;
                r_peak_hi <= win_end ? '0 : peak_hi;
                r_peak_lo <= win_end ? lslt_pkg::PEAK_LOW_RST : peak_lo;
                r_tick    <= win_end ? '0 : tick_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_lprod <= lslt_pkg::LPROD_W'(r_acc.light_total)
                       * lslt_pkg::LPROD_W'(lslt_pkg::LIGHT_RECIP);
            r_aprod <= lslt_pkg::APROD_W'(r_acc.amp_sum)
                       * lslt_pkg::APROD_W'(lslt_pkg::AMP_RECIP);
            r_rep2  <= r_acc.report;
        end
    end

    always_comb begin
        n_avg_l = r_rep2 ? lslt_pkg::LEVEL_W'(r_lprod >> lslt_pkg::LIGHT_SHIFT) : r_avg_l;
        n_avg_a = r_rep2 ? lslt_pkg::AMP_W'(r_aprod >> lslt_pkg::AMP_SHIFT) : r_avg_a;
        n_slamp = lamp_step(n_avg_a >= i_cfg.sound_limit, r_slamp, i_cfg.hold_ticks);
        n_llamp = lamp_step(n_avg_l <= lslt_pkg::LEVEL_W'(i_cfg.light_limit), r_llamp,
                            i_cfg.hold_ticks);
        amp_cap    = (n_avg_a > lslt_pkg::AMP_W'(lslt_pkg::AMP_CAP))
                     ? lslt_pkg::AMP_CAP : lslt_pkg::CAP_W'(n_avg_a);
        round_up   = amp_cap + lslt_pkg::DUTY_ROUND;
        tenth_prod = lslt_pkg::DIV10_W'(round_up) * lslt_pkg::DIV10_RECIP;
        tenth      = lslt_pkg::DUTY_W'(tenth_prod >> lslt_pkg::DIV10_SHIFT);
        n_duty     = i_cfg.sound_lamp_mode ? lslt_pkg::DUTY_OFF : lslt_pkg::DUTY_OFF - tenth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_avg_l <= '0;
            r_avg_a <= '0;
            r_slamp <= '0;
            r_llamp <= '0;
        end else begin
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en3 && r_v2) begin
                r_avg_l <= n_avg_l;
                r_avg_a <= n_avg_a;
                r_slamp <= n_slamp;
                r_llamp <= n_llamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_rep3     <= r_rep2;
            r_sound_on <= i_cfg.sound_lamp_mode && n_slamp.active;
            r_duty     <= n_duty;
        end
    end

    assign o_out.valid             = r_v3;
    assign o_out.light_level       = r_avg_l;
    assign o_out.sound_amplitude   = r_avg_a;
    assign o_out.report_done       = r_rep3;
    assign o_out.sound_lamp_on     = r_sound_on;
    assign o_out.light_lamp_on     = r_llamp.active;
    assign o_out.proportional_duty = r_duty;

endmodule

`default_nettype wire

[hdl/light_sound_level_trigger_top.sv]
// ----------------------------------------------------------------------------
// light_sound_level_trigger_top
// Light and sound level trigger: averages, threshold lamps with hold, duty.
// ----------------------------------------------------------------------------
// Path: an accepted sample pair passes the front register, the queue and the
// accumulate, multiply and lamp stages. Throughput: one sample pair per cycle while
// the result channel is not stalled; the divisions ride in the multiply stage.
// Reset: synchronous, active low; sums, windows, averages and lamps clear,
// registers return to 620 / 500 / 1000 / mode 0, no transfer in flight.
`default_nettype none

module light_sound_level_trigger_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lslt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lslt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    lslt_sample_if.sink                          i_in,
    lslt_result_if.source                        o_out
);

    lslt_pkg::t_cfg        r_cfg;
    lslt_pkg::t_cfg        n_cfg;
    logic                  front_valid;
    logic                  front_ready;
    lslt_pkg::t_front_item front_item;
    logic                  queue_valid;
    logic                  queue_ready;
    lslt_pkg::t_front_item queue_item;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (lslt_pkg::t_cfg_idx'(i_cfg_idx))
                lslt_pkg::CFG_SOUND_THR: begin
                    n_cfg.sound_limit = i_cfg_wdata[lslt_pkg::STHR_W-1:0];
                end
                lslt_pkg::CFG_LIGHT_THR: begin
                    n_cfg.light_limit = i_cfg_wdata[lslt_pkg::LTHR_W-1:0];
                end
                lslt_pkg::CFG_HOLD: begin
                    n_cfg.hold_ticks = i_cfg_wdata[lslt_pkg::HOLD_W-1:0];
                end
                lslt_pkg::CFG_MODE: begin
                    n_cfg.sound_lamp_mode = i_cfg_wdata[0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sound_limit     <= lslt_pkg::SOUND_THR_RST;
            r_cfg.light_limit     <= lslt_pkg::LIGHT_THR_RST;
            r_cfg.hold_ticks      <= lslt_pkg::HOLD_RST;
            r_cfg.sound_lamp_mode <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lslt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    lslt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    lslt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_item  (queue_item),
        .o_out   (o_out)
    );

    a_mode0_sound_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !r_cfg.sound_lamp_mode |-> !o_out.sound_lamp_on)
        else $error("sound lamp on in proportional mode");

    a_mode1_duty_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_cfg.sound_lamp_mode |-> o_out.proportional_duty == lslt_pkg::DUTY_OFF)
        else $error("duty not off in threshold mode");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.light_level <= 17'd65536 && o_out.proportional_duty <= 7'd100)
        else $error("result out of range");

endmodule

`default_nettype wire
